@@ rtl/core/pmst_pkg.sv @@
`default_nettype none

package pmst_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int WEIGHT_BITS_DEF  = 16;

  localparam int VERTEX_BITS    = 6;
  localparam int WEIGHT_IN_BITS = 16;
  localparam int TOTAL_BITS     = 22;
  localparam int COUNT_BITS     = 7;
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 7;

  localparam logic [COUNT_BITS-1:0]  VERTEX_COUNT_RESET = 7'd64;
  localparam logic [VERTEX_BITS-1:0] START_VERTEX_RESET = 6'd0;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_VERTEX_COUNT = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_START_VERTEX = 1'b1;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_RUN  = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_EDGE  = 2'd0,
    ST_TOTAL = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    action_t                     action;
    logic [VERTEX_BITS-1:0]      row_vertex;
    logic [VERTEX_BITS-1:0]      col_vertex;
    logic [WEIGHT_IN_BITS-1:0]   weight;
  } cmd_t;

  typedef struct packed {
    status_t                     status;
    logic [VERTEX_BITS-1:0]      parent_vertex;
    logic [VERTEX_BITS-1:0]      child_vertex;
    logic [WEIGHT_IN_BITS-1:0]   edge_weight;
    logic [TOTAL_BITS-1:0]       total_weight;
    logic                        last;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/core/pmst_stream_if.sv @@
`default_nettype none

interface pmst_stream_if
  import pmst_pkg::*;
#(
  parameter type word_t = cmd_t
);

  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

@@ rtl/core/pmst_ram.sv @@
`default_nettype none

module pmst_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/prim_minimum_spanning_tree.sv @@
`default_nettype none

// channel   dir  handshake       word
// cmd       in   valid/ready     action, row_vertex, col_vertex, weight
// res       out  valid/ready     status, parent/child vertex, edge/total weight, last
// cfg_*     in   cfg_we only     vertex_count (index 0), start_vertex (index 1)
//
// After reset a clearing pass zeroes the matrix, with cmd held off. A load word goes
// straight into the matrix. In a run of n vertices, every step is one key scan and one
// relaxation sweep through the single read port of the vertex store, then a walk of n
// vertices emits the edges. Results sit in one output register; a stalled res holds the
// emit walk and the final total or range-error word.

module prim_minimum_spanning_tree
  import pmst_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  pmst_stream_if.sink                    cmd,
  pmst_stream_if.source                  res,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int VB    = $clog2(MAX_VERTICES);
  localparam int CW    = VB + 1;
  localparam int AW    = 2 * VB;
  localparam int MDEPTH = 1 << AW;
  localparam int KW    = WEIGHT_BITS + 1;
  localparam logic [KW-1:0] KEY_INF = {1'b1, {WEIGHT_BITS{1'b0}}};
  localparam logic [CW-1:0] N_MAX   = CW'(MAX_VERTICES);

  typedef struct packed {
    logic          in_tree;
    logic          has_par;
    logic [VB-1:0] parent;
    logic [KW-1:0] key;
  } vstate_t;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_ERR, S_INIT, S_PICK, S_MARK, S_RELAX,
    S_ERD, S_EPAR, S_EW, S_ETOT
  } state_t;

  state_t                  state;
  logic [AW-1:0]           clr_cnt;
  logic [COUNT_BITS-1:0]   vertex_count;
  logic [VERTEX_BITS-1:0]  start_vertex;
  logic [CW-1:0]           n_reg;
  logic [VB-1:0]           s_reg;
  logic [CW-1:0]           vcnt;
  logic [CW-1:0]           step;
  logic                    pv;
  logic [VB-1:0]           pidx;
  logic [VB-1:0]           best_idx;
  vstate_t                 best_word;
  logic [VB-1:0]           ep;
  logic [TOTAL_BITS-1:0]   total;
  logic                    out_valid;
  res_t                    out_word;

  logic                    accept;
  logic [CW-1:0]           n_eff;
  logic                    start_bad;
  logic                    row_ok;
  logic                    col_ok;
  logic                    out_free;
  logic                    vcnt_lt_n;
  logic                    relax_cond;
  logic                    pick_better;
  logic                    emit_take;

  logic                    m_we;
  logic [AW-1:0]           m_waddr;
  logic [WEIGHT_BITS-1:0]  m_wdata;
  logic                    m_re;
  logic [AW-1:0]           m_raddr;
  logic [WEIGHT_BITS-1:0]  m_rdata;

  logic                    v_we;
  logic [VB-1:0]           v_waddr;
  vstate_t                 v_wdata;
  logic                    v_re;
  logic [VB-1:0]           v_raddr;
  vstate_t                 vs_rd;

  assign cmd.ready = (state == S_IDLE);
  assign res.valid = out_valid;
  assign res.data  = out_word;

  assign accept    = cmd.valid && cmd.ready;
  assign n_eff     = (32'(vertex_count) > MAX_VERTICES) ? N_MAX : CW'(vertex_count);
  assign start_bad = 32'(start_vertex) >= 32'(n_eff);
  assign row_ok    = 32'(cmd.data.row_vertex) < MAX_VERTICES;
  assign col_ok    = 32'(cmd.data.col_vertex) < MAX_VERTICES;
  assign out_free  = !out_valid || res.ready;
  assign vcnt_lt_n = vcnt < n_reg;

  assign relax_cond  = pv && (m_rdata != '0) && !vs_rd.in_tree &&
                       (KW'(m_rdata) < vs_rd.key);
  assign pick_better = pv && !vs_rd.in_tree && (vs_rd.key < best_word.key);
  // the root never gains a parent, the check only mirrors the emit rule
  assign emit_take   = vs_rd.has_par && (vcnt != CW'(s_reg));

  always_comb begin
    m_we    = 1'b0;
    m_waddr = {VB'(cmd.data.row_vertex), VB'(cmd.data.col_vertex)};
    m_wdata = WEIGHT_BITS'(cmd.data.weight);
    m_re    = 1'b0;
    m_raddr = {best_idx, vcnt[VB-1:0]};
    case (state)
      S_CLR: begin
        m_we    = 1'b1;
        m_waddr = clr_cnt;
        m_wdata = '0;
      end
      S_IDLE: begin
        m_we = accept && (cmd.data.action == ACT_LOAD) && row_ok && col_ok;
      end
      S_RELAX: begin
        m_re = vcnt_lt_n;
      end
      S_EPAR: begin
        m_re    = emit_take;
        m_raddr = {vcnt[VB-1:0], vs_rd.parent};
      end
      default: ;
    endcase
  end

  always_comb begin
    v_we    = 1'b0;
    v_waddr = vcnt[VB-1:0];
    v_wdata = '{in_tree: 1'b0, has_par: 1'b0, parent: '0,
                key: (vcnt == CW'(s_reg)) ? '0 : KEY_INF};
    v_re    = 1'b0;
    v_raddr = vcnt[VB-1:0];
    case (state)
      S_INIT: begin
        v_we = 1'b1;
      end
      S_PICK: begin
        v_re = vcnt_lt_n;
      end
      S_MARK: begin
        v_we            = 1'b1;
        v_waddr         = best_idx;
        v_wdata         = best_word;
        v_wdata.in_tree = 1'b1;
      end
      S_RELAX: begin
        v_re    = vcnt_lt_n;
        v_we    = relax_cond;
        v_waddr = pidx;
        v_wdata = '{in_tree: 1'b0, has_par: 1'b1, parent: best_idx, key: KW'(m_rdata)};
      end
      S_ERD: begin
        v_re = vcnt_lt_n;
      end
      default: ;
    endcase
  end

  pmst_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (MDEPTH)
  ) u_matrix (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .re    (m_re),
    .raddr (m_raddr),
    .rdata (m_rdata)
  );

  pmst_ram #(
    .WIDTH ($bits(vstate_t)),
    .DEPTH (1 << VB)
  ) u_vstate (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (v_wdata),
    .re    (v_re),
    .raddr (v_raddr),
    .rdata (vs_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLR;
      clr_cnt      <= '0;
      vertex_count <= VERTEX_COUNT_RESET;
      start_vertex <= START_VERTEX_RESET;
      out_valid    <= 1'b0;
      pv           <= 1'b0;
      vcnt         <= '0;
      step         <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_VERTEX_COUNT: vertex_count <= cfg_data;
          CFG_START_VERTEX: start_vertex <= cfg_data[VERTEX_BITS-1:0];
          default: ;
        endcase
      end

      if (out_valid && res.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept && (cmd.data.action == ACT_RUN)) begin
            n_reg <= n_eff;
            s_reg <= VB'(start_vertex);
            vcnt  <= '0;
            total <= '0;
            state <= start_bad ? S_ERR : S_INIT;
          end
        end
        S_ERR: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_word  <= '{status: ST_RANGE, parent_vertex: '0, child_vertex: '0,
                           edge_weight: '0, total_weight: '0, last: 1'b1};
            state     <= S_IDLE;
          end
        end
        S_INIT: begin
          vcnt <= vcnt + 1'b1;
          if (vcnt == n_reg - 1'b1) begin
            vcnt          <= '0;
            step          <= '0;
            pv            <= 1'b0;
            best_word.key <= KEY_INF;
            state         <= (n_reg > CW'(1)) ? S_PICK : S_ERD;
          end
        end
        S_PICK: begin
          pv   <= vcnt_lt_n;
          pidx <= vcnt[VB-1:0];
          if (vcnt_lt_n) begin
            vcnt <= vcnt + 1'b1;
          end
          if (pick_better) begin
            best_word <= vs_rd;
            best_idx  <= pidx;
          end
          if (!vcnt_lt_n && !pv) begin
            vcnt  <= '0;
            // nothing reachable left: partial tree
            state <= (best_word.key == KEY_INF) ? S_ERD : S_MARK;
          end
        end
        S_MARK: begin
          vcnt  <= '0;
          pv    <= 1'b0;
          state <= S_RELAX;
        end
        S_RELAX: begin
          pv   <= vcnt_lt_n;
          pidx <= vcnt[VB-1:0];
          if (vcnt_lt_n) begin
            vcnt <= vcnt + 1'b1;
          end
          if (!vcnt_lt_n && !pv) begin
            step          <= step + 1'b1;
            vcnt          <= '0;
            best_word.key <= KEY_INF;
            state         <= (({1'b0, step} + (CW+1)'(2)) < {1'b0, n_reg}) ? S_PICK : S_ERD;
          end
        end
        S_ERD: begin
          state <= vcnt_lt_n ? S_EPAR : S_ETOT;
        end
        S_EPAR: begin
          if (emit_take) begin
            ep    <= vs_rd.parent;
            state <= S_EW;
          end else begin
            vcnt  <= vcnt + 1'b1;
            state <= S_ERD;
          end
        end
        S_EW: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_word  <= '{status: ST_EDGE, parent_vertex: VERTEX_BITS'(ep),
                           child_vertex: VERTEX_BITS'(vcnt[VB-1:0]),
                           edge_weight: WEIGHT_IN_BITS'(m_rdata),
                           total_weight: '0, last: 1'b0};
            total     <= total + TOTAL_BITS'(m_rdata);
            vcnt      <= vcnt + 1'b1;
            state     <= S_ERD;
          end
        end
        S_ETOT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_word  <= '{status: ST_TOTAL, parent_vertex: '0, child_vertex: '0,
                           edge_weight: '0, total_weight: total, last: 1'b1};
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
